### design/assert_macros.svh
// Assertion macros shared by the queue bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define MQRB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define MQRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// Consequent holds in the cycle after the antecedent.
`define MQRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### design/mqrb_pkg.sv
// Shared types and constants of the message queue bank.
package mqrb_pkg;

    // Command codes
    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_READ   = 3'd3,
        CMD_POLL   = 3'd4
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SLOT   = 3'd1,
        ST_BAD_REF   = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_NEAR_FULL = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    localparam int unsigned FieldMsgBits   = 32;
    localparam int unsigned FieldCountBits = 6;
    localparam int unsigned FieldSlotBits  = 3;
    localparam int unsigned ThreshBits     = 5;
    localparam logic [ThreshBits-1:0] CloseThresholdReset = 5'd5;

    // Store access issued for one command
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_op;

    // Result word minus the store read data
    typedef struct packed {
        t_status                   status;
        logic [FieldSlotBits-1:0]  new_queue;
        logic [FieldCountBits-1:0] unread_count;
        logic [FieldCountBits-1:0] dropped_count;
        logic                      from_mem;
    } t_result;

endpackage

### design/multi_queue_ring_buffer.sv
// Top level of the multi-queue ring buffer: command channel, store, result register.
//
// Usage:
//  - Command channel: i_in_valid / o_in_stall carry one word (i_cmd, i_queue_ref,
//    i_message_in); a word is taken on a clock edge with valid high, stall low.
//  - Result channel: o_out_valid / i_out_stall carry one result word per command
//    (o_status, o_new_queue, o_message_out, o_unread_count, o_dropped_count).
//  - The result is registered: it is valid in the cycle after the command is taken.
//  - Throughput: one command per cycle while o_in_stall is low; each command
//    touches one slot's pointers and one store entry through the single RAM
//    port, and the RAM's registered read lines up with the result register.
//  - Stall: a held result stays put while i_out_stall is high, and o_in_stall
//    is raised for that time so no further command is taken.
//  - Reset (synchronous, active low): slot 0 allocated and empty, other slots
//    free, threshold back to 5, result register empty. The message store is
//    not cleared; an entry is only read after an add has written it.
//  - i_cfg_we / i_cfg_wdata write the close threshold; write only when idle.
`include "assert_macros.svh"

module multi_queue_ring_buffer
    import mqrb_pkg::*;
#(
    parameter int unsigned QUEUE_SLOTS  = 3,
    parameter int unsigned QUEUE_DEPTH  = 32,
    parameter int unsigned MESSAGE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_queue_ref,
    input  logic [31:0] i_message_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_new_queue,
    output logic [31:0] o_message_out,
    output logic [5:0]  o_unread_count,
    output logic [5:0]  o_dropped_count
);

    // Stored word width: the message field caps it
    localparam int unsigned STORE_BITS = (MESSAGE_BITS < FieldMsgBits) ?
                                         MESSAGE_BITS : FieldMsgBits;
    localparam int unsigned MEM_DEPTH  = QUEUE_SLOTS * QUEUE_DEPTH;
    localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);

    logic                  in_fire;
    t_mem_op               mem_op;
    logic [ADDR_W-1:0]     mem_addr;
    logic [STORE_BITS-1:0] mem_wdata;
    logic [STORE_BITS-1:0] mem_rdata;
    t_result               result;

    logic                  r_out_valid;
    t_result               r_res;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    mqrb_ctrl #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STORE_BITS  (STORE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (in_fire),
        .i_cmd        (i_cmd),
        .i_queue_ref  (i_queue_ref),
        .i_message_in (i_message_in),
        .o_mem_op     (mem_op),
        .o_mem_addr   (mem_addr),
        .o_mem_wdata  (mem_wdata),
        .o_result     (result)
    );

    // Message store, one region of QUEUE_DEPTH words per slot
    mqrb_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_op.wr),
        .i_re    (mem_op.rd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; RAM read data lines up with it
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_res.status;
    assign o_new_queue     = r_res.new_queue;
    assign o_message_out   = r_res.from_mem ? FieldMsgBits'(mem_rdata) : '0;
    assign o_unread_count  = r_res.unread_count;
    assign o_dropped_count = r_res.dropped_count;

    `MQRB_ASSERT_IMPL(a_mem_ok, i_clk, i_rst_n, r_out_valid && r_res.from_mem,
        r_res.status == ST_OK)
    `MQRB_ASSERT_IMPL(a_drop_ok, i_clk, i_rst_n, r_out_valid && (r_res.dropped_count != '0),
        r_res.status == ST_OK)
    `MQRB_ASSERT_NEXT(a_fire_valid, i_clk, i_rst_n, in_fire, o_out_valid)

endmodule

### design/mqrb_ram.sv
// Generic single-port RAM with registered read.
module mqrb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/mqrb_ctrl.sv
// Queue slot table, pointers, counts and command decode.
`include "assert_macros.svh"

module mqrb_ctrl
    import mqrb_pkg::*;
#(
    parameter int unsigned QUEUE_SLOTS = 3,
    parameter int unsigned QUEUE_DEPTH = 32,
    parameter int unsigned STORE_BITS  = 32,
    parameter int unsigned ADDR_W      = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ThreshBits-1:0]       i_cfg_wdata,
    input  logic                        i_accept,
    input  logic [2:0]                  i_cmd,
    input  logic [FieldSlotBits-1:0]    i_queue_ref,
    input  logic [FieldMsgBits-1:0]     i_message_in,
    output t_mem_op                     o_mem_op,
    output logic [ADDR_W-1:0]           o_mem_addr,
    output logic [STORE_BITS-1:0]       o_mem_wdata,
    output t_result                     o_result
);

    localparam int unsigned SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMP_W  = (CNT_W > ThreshBits) ? CNT_W : ThreshBits;

    logic [ThreshBits-1:0] r_thresh;
    logic                  r_alloc [QUEUE_SLOTS];
    logic [PTR_W-1:0]      r_rd    [QUEUE_SLOTS];
    logic [PTR_W-1:0]      r_wr    [QUEUE_SLOTS];
    logic [CNT_W-1:0]      r_cnt   [QUEUE_SLOTS];

    logic                  n_alloc [QUEUE_SLOTS];
    logic [PTR_W-1:0]      n_rd    [QUEUE_SLOTS];
    logic [PTR_W-1:0]      n_wr    [QUEUE_SLOTS];
    logic [CNT_W-1:0]      n_cnt   [QUEUE_SLOTS];

    logic [SLOT_W-1:0]     sel;
    logic                  bad_ref;
    logic                  cmd_known;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [CNT_W-1:0]      free_entries;
    logic [PTR_W-1:0]      ptr;

    assign sel       = i_queue_ref[SLOT_W-1:0];
    assign bad_ref   = {1'b0, i_queue_ref} >= 4'(QUEUE_SLOTS);
    assign cmd_known = i_cmd <= CMD_POLL;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = QUEUE_SLOTS - 1; s >= 0; s--) begin
            if (!r_alloc[s]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        n_alloc      = r_alloc;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_cnt        = r_cnt;
        o_mem_op     = '0;
        ptr          = '0;
        free_entries = '0;
        o_result     = '{status: ST_OK, new_queue: '0, unread_count: '0,
                         dropped_count: '0, from_mem: 1'b0};

        if (t_cmd'(i_cmd) == CMD_CREATE) begin
            if (free_found) begin
                o_result.new_queue = FieldSlotBits'(free_idx);
                if (i_accept) begin
                    n_alloc[free_idx] = 1'b1;
                    n_rd[free_idx]    = '0;
                    n_wr[free_idx]    = '0;
                    n_cnt[free_idx]   = '0;
                end
            end else begin
                o_result.status = ST_NO_SLOT;
            end
        end else if (!cmd_known || bad_ref) begin
            o_result.status = ST_BAD_REF;
        end else if (!r_alloc[sel]) begin
            o_result.status = ST_NOT_ALLOC;
        end else begin
            unique case (t_cmd'(i_cmd))
                CMD_REMOVE: begin
                    o_result.dropped_count = FieldCountBits'(r_cnt[sel]);
                    if (i_accept) begin
                        n_alloc[sel] = 1'b0;
                        n_rd[sel]    = '0;
                        n_wr[sel]    = '0;
                        n_cnt[sel]   = '0;
                    end
                end
                CMD_ADD: begin
                    free_entries = CNT_W'(QUEUE_DEPTH) - r_cnt[sel];
                    ptr          = r_wr[sel];
                    if (CMP_W'(free_entries) <= CMP_W'(r_thresh)) begin
                        o_result.status       = ST_NEAR_FULL;
                        o_result.unread_count = FieldCountBits'(r_cnt[sel]);
                    end else begin
                        o_result.unread_count = FieldCountBits'(r_cnt[sel] + 1'b1);
                        o_mem_op.wr           = i_accept;
                        if (i_accept) begin
                            n_wr[sel]  = (r_wr[sel] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : r_wr[sel] + 1'b1;
                            n_cnt[sel] = r_cnt[sel] + 1'b1;
                        end
                    end
                end
                CMD_READ: begin
                    ptr = r_rd[sel];
                    if (r_cnt[sel] == '0) begin
                        o_result.status = ST_EMPTY;
                    end else begin
                        o_result.unread_count = FieldCountBits'(r_cnt[sel] - 1'b1);
                        o_result.from_mem     = 1'b1;
                        o_mem_op.rd           = i_accept;
                        if (i_accept) begin
                            n_rd[sel]  = (r_rd[sel] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : r_rd[sel] + 1'b1;
                            n_cnt[sel] = r_cnt[sel] - 1'b1;
                        end
                    end
                end
                CMD_POLL: begin
                    o_result.unread_count = FieldCountBits'(r_cnt[sel]);
                    if (r_cnt[sel] == '0) begin
                        o_result.status = ST_EMPTY;
                    end
                end
                default: begin
                    o_result.status = ST_BAD_REF;
                end
            endcase
        end
    end

    // Store address: slot base plus pointer
    assign o_mem_addr  = ADDR_W'(ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(ptr);
    assign o_mem_wdata = STORE_BITS'(i_message_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= CloseThresholdReset;
            for (int s = 0; s < QUEUE_SLOTS; s++) begin
                r_alloc[s] <= (s == 0);
                r_rd[s]    <= '0;
                r_wr[s]    <= '0;
                r_cnt[s]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            r_alloc <= n_alloc;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_cnt   <= n_cnt;
        end
    end

    `MQRB_ASSERT_ALWAYS(a_one_access, i_clk, i_rst_n, !(o_mem_op.wr && o_mem_op.rd))

    for (genvar g = 0; g < QUEUE_SLOTS; g++) begin : g_chk
        `MQRB_ASSERT_IMPL(a_ptr_match, i_clk, i_rst_n,
            (r_cnt[g] == '0) || (r_cnt[g] == CNT_W'(QUEUE_DEPTH)), r_rd[g] == r_wr[g])
        `MQRB_ASSERT_IMPL(a_free_empty, i_clk, i_rst_n, !r_alloc[g], r_cnt[g] == '0)
    end

endmodule

### test/tb_multi_queue_ring_buffer.sv
// Self-checking testbench for the multi-queue ring buffer: random command words against a predictor.
`timescale 1ns / 1ps

module tb_multi_queue_ring_buffer
    import mqrb_pkg::*;
;

    // Bank shape under test; the predictor is sized to match.
    localparam int QSLOTS = 3;
    localparam int QDEPTH = 32;

    // Top values of the command and queue fields (3 bits each).
    localparam logic [2:0] CMD_FIELD_MAX = '1;
    localparam logic [2:0] REF_FIELD_MAX = '1;

    // Idle cycles seen before a threshold write, and the tail wait at the end.
    localparam int SETTLE_CYCLES = 3;
    localparam int DRAIN_CYCLES  = 8;

    // Results to let through before each long receiver hold-off.
    localparam int HOLD_AT_FIRST  = 250;
    localparam int HOLD_AT_SECOND = 700;
    localparam int HOLD_CYCLES    = 96;

    // One backlog entry: either a command word or a threshold write.
    typedef struct {
        bit          is_cfg;
        logic [4:0]  thresh;
        logic [2:0]  cmd;
        logic [2:0]  qref;
        logic [31:0] msg;
    } t_cmd_word;

    // One result word as the bank should return it.
    typedef struct {
        t_status     status;
        logic [2:0]  new_queue;
        logic [31:0] message_out;
        logic [5:0]  unread_count;
        logic [5:0]  dropped_count;
    } t_bank_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [4:0]  i_cfg_wdata     = '0;
    logic        i_in_valid      = 1'b0;
    logic [2:0]  i_cmd           = '0;
    logic [2:0]  i_queue_ref     = '0;
    logic [31:0] i_message_in    = '0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [2:0]  o_new_queue;
    logic [31:0] o_message_out;
    logic [5:0]  o_unread_count;
    logic [5:0]  o_dropped_count;

    multi_queue_ring_buffer #(
        .QUEUE_SLOTS  (QSLOTS),
        .QUEUE_DEPTH  (QDEPTH),
        .MESSAGE_BITS (32)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_queue_ref     (i_queue_ref),
        .i_message_in    (i_message_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_new_queue     (o_new_queue),
        .o_message_out   (o_message_out),
        .o_unread_count  (o_unread_count),
        .o_dropped_count (o_dropped_count)
    );

    // Words waiting to be offered, and results owed by the bank, oldest first.
    t_cmd_word    cmd_backlog[$];
    t_bank_result results_due[$];

    // Predictor copy of the bank state and the threshold register.
    bit          slot_live  [QSLOTS];
    int          head_idx   [QSLOTS];
    int          tail_idx   [QSLOTS];
    int          fill_level [QSLOTS];
    logic [31:0] msg_store  [QSLOTS][QDEPTH];
    logic [4:0]  close_thresh = CloseThresholdReset;

    int error_count   = 0;
    int words_queued  = 0;
    int results_taken = 0;

    // Sender pacing
    int burst_left  = 0;
    int gap_left    = 0;
    int idle_cycles = 0;

    // Receiver pacing
    int hold_left  = 0;
    int seg_left   = 0;
    int stall_mode = 0;

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command word to the shadow bank and returns
    // the result word it should produce.
    // ------------------------------------------------------------------
    function automatic t_bank_result bank_apply(input logic [2:0] op, input logic [2:0] qref,
                                                input logic [31:0] msg);
        t_bank_result r;
        int           slot;
        r.status        = ST_OK;
        r.new_queue     = '0;
        r.message_out   = '0;
        r.unread_count  = '0;
        r.dropped_count = '0;
        slot            = -1;
        if (op == CMD_CREATE) begin
            // lowest free slot wins; queue_ref is don't-care here
            for (int s = QSLOTS - 1; s >= 0; s--) begin
                if (!slot_live[s]) slot = s;
            end
            if (slot < 0) begin
                r.status = ST_NO_SLOT;
            end else begin
                slot_live[slot]  = 1'b1;
                head_idx[slot]   = 0;
                tail_idx[slot]   = 0;
                fill_level[slot] = 0;
                r.new_queue      = 3'(slot);
            end
        end else if (op > CMD_POLL || qref >= QSLOTS) begin
            // unknown opcodes fold into bad ref; checked ahead of allocation
            r.status = ST_BAD_REF;
        end else if (!slot_live[qref]) begin
            r.status = ST_NOT_ALLOC;
        end else begin
            case (op)
                CMD_REMOVE: begin
                    r.dropped_count  = 6'(fill_level[qref]);
                    slot_live[qref]  = 1'b0;
                    head_idx[qref]   = 0;
                    tail_idx[qref]   = 0;
                    fill_level[qref] = 0;
                end
                CMD_ADD: begin
                    // refuse once free entries drop to the threshold
                    if (QDEPTH - fill_level[qref] <= int'(close_thresh)) begin
                        r.status = ST_NEAR_FULL;
                    end else begin
                        msg_store[qref][tail_idx[qref]] = msg;
                        tail_idx[qref] = (tail_idx[qref] == QDEPTH - 1) ? 0 : tail_idx[qref] + 1;
                        fill_level[qref]++;
                    end
                    r.unread_count = 6'(fill_level[qref]);
                end
                CMD_READ: begin
                    if (fill_level[qref] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.message_out  = msg_store[qref][head_idx[qref]];
                        head_idx[qref] = (head_idx[qref] == QDEPTH - 1) ? 0 : head_idx[qref] + 1;
                        fill_level[qref]--;
                    end
                    r.unread_count = 6'(fill_level[qref]);
                end
                default: begin
                    // poll: no state change
                    if (fill_level[qref] == 0) r.status = ST_EMPTY;
                    r.unread_count = 6'(fill_level[qref]);
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_word(input logic [2:0] op, input logic [2:0] qref, input logic [31:0] msg);
        t_cmd_word w;
        w.is_cfg = 1'b0;
        w.thresh = '0;
        w.cmd    = op;
        w.qref   = qref;
        w.msg    = msg;
        cmd_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic push_thresh(input logic [4:0] value);
        t_cmd_word w;
        w.is_cfg = 1'b1;
        w.thresh = value;
        w.cmd    = CMD_POLL;
        w.qref   = '0;
        w.msg    = '0;
        cmd_backlog.push_back(w);
    endtask

    // Mostly well-formed traffic on valid queue refs, with fill/drain runs to reach
    // the threshold and pointer wrap, plus a share of bad refs and bad opcodes.
    task automatic push_random(input int count);
        int         target;
        int         pick;
        int         run;
        logic [2:0] q;
        target = words_queued + count;
        while (words_queued < target) begin
            pick = $urandom_range(0, 99);
            q    = 3'($urandom_range(0, QSLOTS - 1));
            if (pick < 8) begin
                // make every slot live, then fill one queue and drain part or all of it
                run = $urandom_range(8, QDEPTH + 4);
                repeat (QSLOTS) push_word(CMD_CREATE, 3'($urandom_range(0, 7)), $urandom);
                repeat (run) push_word(CMD_ADD, q, $urandom);
                repeat ($urandom_range(run / 2, run + 2)) push_word(CMD_READ, q, $urandom);
            end else if (pick < 14) begin
                push_word(CMD_CREATE, 3'($urandom_range(0, 7)), $urandom);
            end else if (pick < 19) begin
                push_word(CMD_REMOVE, q, $urandom);
            end else if (pick < 52) begin
                push_word(CMD_ADD, q, $urandom);
            end else if (pick < 80) begin
                push_word(CMD_READ, q, $urandom);
            end else if (pick < 90) begin
                push_word(CMD_POLL, q, $urandom);
            end else if (pick < 95) begin
                push_word(3'($urandom_range(int'(CMD_POLL) + 1, CMD_FIELD_MAX)),
                          3'($urandom_range(0, REF_FIELD_MAX)), $urandom);
            end else begin
                push_word(3'($urandom_range(CMD_REMOVE, CMD_POLL)),
                          3'($urandom_range(QSLOTS, REF_FIELD_MAX)), $urandom);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers backlog words in bursts with random gaps. Valid and the
    // payload only move once the current word is taken or the line is idle.
    // A threshold write waits until every owed result has come back.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd_word w;
        logic      valid_nxt;
        logic      we_nxt;
        valid_nxt = i_in_valid;
        we_nxt    = 1'b0;
        if (!i_rst_n) begin
            valid_nxt = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                results_due.push_back(bank_apply(i_cmd, i_queue_ref, i_message_in));
                valid_nxt = 1'b0;
            end
            if (!valid_nxt && cmd_backlog.size() != 0) begin
                w = cmd_backlog[0];
                if (w.is_cfg) begin
                    idle_cycles = (results_due.size() == 0) ? idle_cycles + 1 : 0;
                    if (idle_cycles > SETTLE_CYCLES) begin
                        we_nxt       = 1'b1;
                        i_cfg_wdata <= w.thresh;
                        close_thresh = w.thresh;
                        idle_cycles  = 0;
                        cmd_backlog.delete(0);
                    end
                end else if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    cmd_backlog.delete(0);
                    i_cmd        <= w.cmd;
                    i_queue_ref  <= w.qref;
                    i_message_in <= w.msg;
                    valid_nxt     = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // a third of bursts run straight into the next one
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        i_in_valid <= valid_nxt;
        i_cfg_we   <= we_nxt;
    end

    // ------------------------------------------------------------------
    // Monitor: takes result words, checks each against the oldest owed one,
    // and drives the receiver stall pattern. Two long hold-offs back the bank
    // up so that it stalls its input while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bank_result due;
        logic         stall_nxt;
        stall_nxt = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result word with nothing owed: status %0d", o_status);
                    error_count++;
                end else begin
                    due = results_due.pop_front();
                    check_field("status", due.status, o_status);
                    check_field("new_queue", due.new_queue, o_new_queue);
                    check_field("message_out", due.message_out, o_message_out);
                    check_field("unread_count", due.unread_count, o_unread_count);
                    check_field("dropped_count", due.dropped_count, o_dropped_count);
                end
                results_taken++;
                if (results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_SECOND)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                stall_nxt = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left   = $urandom_range(8, 64);
                    stall_mode = $urandom_range(0, 3);
                end
                seg_left--;
                case (stall_mode)
                    0:       stall_nxt = 1'b0;                          // free flow
                    1:       stall_nxt = ($urandom_range(0, 3) == 0);   // light
                    2:       stall_nxt = ($urandom_range(0, 3) != 0);   // heavy
                    default: stall_nxt = !i_out_stall;                  // alternating
                endcase
            end
        end
        i_out_stall <= stall_nxt;
    end

    // ------------------------------------------------------------------
    // Sequence: directed words, then random phases under several thresholds.
    // ------------------------------------------------------------------
    initial begin
        for (int s = 0; s < QSLOTS; s++) begin
            slot_live[s]  = (s == 0);
            head_idx[s]   = 0;
            tail_idx[s]   = 0;
            fill_level[s] = 0;
        end

        // queue 0 is live out of reset: empty poll/read, extreme words through it
        push_word(CMD_POLL, 3'd0, '0);
        push_word(CMD_READ, 3'd0, '0);
        push_word(CMD_ADD, 3'd0, 32'h0000_0000);
        push_word(CMD_ADD, 3'd0, 32'hFFFF_FFFF);
        push_word(CMD_POLL, 3'd0, '1);
        push_word(CMD_READ, 3'd0, '0);
        push_word(CMD_READ, 3'd0, '1);
        push_word(CMD_READ, 3'd0, '0);
        // bad refs and unknown opcodes
        push_word(CMD_ADD, 3'(QSLOTS), 32'h1234_5678);
        push_word(CMD_POLL, REF_FIELD_MAX, '0);
        push_word(3'(CMD_POLL + 1), 3'd0, '0);
        push_word(3'(CMD_POLL + 2), 3'd1, '1);
        push_word(CMD_FIELD_MAX, REF_FIELD_MAX, '1);
        // slots not yet created
        push_word(CMD_READ, 3'd1, '0);
        push_word(CMD_REMOVE, 3'd2, '0);
        push_word(CMD_ADD, 3'd1, 32'hDEAD_BEEF);
        // allocate everything, then one create too many
        push_word(CMD_CREATE, REF_FIELD_MAX, '0);
        push_word(CMD_CREATE, 3'd0, '0);
        push_word(CMD_CREATE, 3'd2, '0);
        // remove with and without pending words, then reuse the lowest slot
        push_word(CMD_ADD, 3'd2, 32'hA5A5_A5A5);
        push_word(CMD_ADD, 3'd2, 32'h5A5A_5A5A);
        push_word(CMD_REMOVE, 3'd2, '0);
        push_word(CMD_REMOVE, 3'd1, '0);
        push_word(CMD_CREATE, 3'd1, '0);
        push_word(CMD_CREATE, 3'd0, '0);

        push_random(200);

        // threshold zero: a queue can fill completely; overfill, then drain past empty
        push_thresh(5'd0);
        repeat (QSLOTS) push_word(CMD_CREATE, '0, '0);
        repeat (QDEPTH + 1) push_word(CMD_ADD, 3'd1, $urandom);
        push_word(CMD_POLL, 3'd1, '0);
        repeat (QDEPTH + 1) push_word(CMD_READ, 3'd1, '0);
        push_random(150);

        // top threshold: only an empty queue takes an add
        push_thresh(5'd31);
        push_random(100);

        push_thresh(5'd1);
        push_random(150);

        push_thresh(5'($urandom_range(2, 30)));
        push_random(150);

        push_thresh(CloseThresholdReset);
        push_random(50);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_in_valid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
